@@ src/paw_pkg.sv @@
// shared constants and types for the projection angle weight block
`default_nettype none
package paw_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 8;
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int Depth = MaxRows * MaxCols;
  localparam logic [32:0] PiQ30 = 33'd3373259426;
  localparam logic [32:0] HalfPiQ30 = 33'd1686629713;
  localparam logic [33:0] TwoPiQ30 = 34'd6746518852;
  localparam int CordicSteps = 31;

  localparam logic [0:0] ModeWrite = 1'b0;
  localparam logic [0:0] ModeQuery = 1'b1;
  localparam logic [0:0] RegRows = 1'b0;
  localparam logic [0:0] RegCols = 1'b1;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'd843314857;
      5'd1: v = 30'd497837829;
      5'd2: v = 30'd263043837;
      5'd3: v = 30'd133525159;
      5'd4: v = 30'd67021687;
      5'd5: v = 30'd33543516;
      5'd6: v = 30'd16775851;
      5'd7: v = 30'd8388437;
      5'd8: v = 30'd4194283;
      5'd9: v = 30'd2097149;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic        go;
    logic [83:0] rad;
    logic [42:0] dot;
  } ang_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] angle;
  } ang_rsp_t;
endpackage
`default_nettype wire

@@ src/paw_angle.sv @@
// square root, then vectoring cordic for the angle term, one step a cycle
`default_nettype none
module paw_angle (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire paw_pkg::ang_req_t req,
  output paw_pkg::ang_rsp_t      rsp
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SQRT = 5'b00010,
    S_NORM = 5'b00100,
    S_CORD = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t       state;
  logic [5:0]   cnt;
  logic [83:0]  rad;
  logic [41:0]  root;
  logic [43:0]  srem;
  logic [42:0]  dot;
  logic signed [45:0] x, y;
  logic signed [34:0] z;
  logic [45:0]  rem_sh;
  logic [45:0]  sq_try;
  logic [42:0]  xmag;
  logic [42:0]  mx;
  logic signed [45:0] xs, ys;
  logic [4:0]   step;

  always_comb begin
    rem_sh = {srem, rad[83:82]};
    sq_try = rem_sh - {2'b00, root, 2'b01};
    xmag = dot[42] ? 43'(-dot) : dot;
    mx = (xmag > 43'(root)) ? xmag : 43'(root);
    step = cnt[4:0];
    xs = x >>> step;
    ys = y >>> step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (req.go) begin
            rad <= req.rad;
            dot <= req.dot;
            root <= '0;
            srem <= '0;
            cnt <= 6'd41;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (!sq_try[45]) begin
            srem <= sq_try[43:0];
            root <= {root[40:0], 1'b1};
          end else begin
            srem <= rem_sh[43:0];
            root <= {root[40:0], 1'b0};
          end
          rad <= rad << 2;
          if (cnt == 6'd0) state <= S_NORM;
          else cnt <= cnt - 6'd1;
        end
        S_NORM: begin
          if (mx == '0) begin
            z <= '0;
            state <= S_DONE;
          end else if (mx < (43'd1 << 40)) begin
            root <= root << 1;
            if (dot[42]) dot <= 43'(-(xmag << 1));
            else dot <= xmag << 1;
          end else begin
            cnt <= '0;
            if (dot[42]) begin
              x <= 46'(root);
              y <= 46'(xmag);
              z <= 35'(paw_pkg::HalfPiQ30);
            end else begin
              x <= 46'(xmag);
              y <= 46'(root);
              z <= 35'sd0;
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (y > 0) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + 35'(paw_pkg::atan_q30(step));
          end else if (y < 0) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - 35'(paw_pkg::atan_q30(step));
          end
          if (cnt == 6'(paw_pkg::CordicSteps - 1)) state <= S_DONE;
          else cnt <= cnt + 6'd1;
        end
        S_DONE: begin
          if (z < 0) rsp.angle <= '0;
          else if (z > 35'(paw_pkg::PiQ30)) rsp.angle <= paw_pkg::PiQ30;
          else rsp.angle <= z[32:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("angle done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> !rsp.done || $past(state == S_DONE))
    else $error("angle done out of order");
  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.angle <= paw_pkg::PiQ30) else $error("angle out of range");
`endif
endmodule
`default_nettype wire

@@ src/projection_angle_weight.sv @@
// top level: sample store, distance accumulation, sequencer and final divide
//
// channel  | ports                                      | dir
// command  | start busy mode row_a row_b column sample  | in, busy out
// result   | done weight                                | out
// config   | cfg_we cfg_index cfg_data                  | in
//
// a write is taken while idle and never raises busy
// a query holds busy until its weight is ready, done follows; per row it runs
// reads and multiply-accumulates per coordinate, a 36x18 product pass and
// root/cordic for an angle row, then a 41-step restoring divide
// rst is synchronous; the store is not cleared. results cannot stall
`default_nettype none
module projection_angle_weight (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [0:0]  mode,
  input  wire logic [paw_pkg::RowW-1:0] row_a,
  input  wire logic [paw_pkg::RowW-1:0] row_b,
  input  wire logic [paw_pkg::ColW-1:0] column,
  input  wire logic signed [15:0] sample,
  output logic             done,
  output logic [18:0]      weight,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [6:0]  cfg_data
);
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RD   = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_ROW  = 9'b000001000,
    S_P1   = 9'b000010000,
    S_P2   = 9'b000100000,
    S_ANG  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  logic [6:0] rows_in_use;
  logic [3:0] cols_in_use;
  logic [15:0] mem [paw_pkg::Depth];
  logic [15:0] rd;
  logic [1:0]  ph;
  logic [6:0]  n, n_cfg;
  logic [3:0]  k, k_cfg;
  logic [paw_pkg::RowW-1:0] ja, lb, r;
  logic [paw_pkg::ColW-1:0] c;
  logic signed [15:0] vj, vl;
  logic signed [37:0] dot, djr, dlr, djl;
  logic [39:0] sum;
  logic [35:0] mul_a, mul_b;
  logic [17:0] mul_bh;
  logic [53:0] prod;
  logic [35:0] dmag;
  logic [83:0] pp, qq;
  logic [2:0]  pstep;
  logic [5:0]  dcnt;
  logic [40:0] num, quo;
  logic [40:0] rem;
  logic [40:0] den;
  logic [41:0] rem_try;
  logic [1:0]  mstep;
  logic signed [16:0] da, db, dd;
  logic signed [16:0] mop_a, mop_b;
  logic signed [33:0] mprod;
  paw_pkg::ang_req_t areq;
  paw_pkg::ang_rsp_t arsp;

  paw_angle u_ang (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  assign busy = (state != S_IDLE);
  assign da = 17'(vj) - 17'($signed(rd));
  assign db = 17'(vl) - 17'($signed(rd));
  assign dd = 17'(vj) - 17'(vl);
  assign mprod = 34'(mop_a) * 34'(mop_b);
  assign mul_bh = pstep[0] ? mul_b[35:18] : mul_b[17:0];
  assign prod = 54'(mul_a) * 54'(mul_bh);
  assign dmag = 36'(dot[37] ? -dot : dot);
  assign rem_try = {rem, num[40]} - 42'(den);

  always_comb begin
    case (mstep)
      2'd0: begin mop_a = da; mop_b = db; end
      2'd1: begin mop_a = da; mop_b = da; end
      2'd2: begin mop_a = db; mop_b = db; end
      default: begin mop_a = dd; mop_b = dd; end
    endcase
    if (rows_in_use == 7'd0) n_cfg = 7'd1;
    else if (rows_in_use > 7'(paw_pkg::MaxRows)) n_cfg = 7'(paw_pkg::MaxRows);
    else n_cfg = rows_in_use;
    if (cols_in_use == 4'd0) k_cfg = 4'd1;
    else if (cols_in_use > 4'(paw_pkg::MaxCols)) k_cfg = 4'(paw_pkg::MaxCols);
    else k_cfg = cols_in_use;
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && mode == paw_pkg::ModeWrite)
      mem[{row_a, column}] <= sample;
    if (state == S_RD) begin
      case (ph)
        2'd0: rd <= mem[{ja, c}];
        2'd1: rd <= mem[{lb, c}];
        default: rd <= mem[{r, c}];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= 7'd64;
      cols_in_use <= 4'd8;
      state <= S_IDLE;
      done <= 1'b0;
      areq.go <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      areq.go <= (state == S_P1) && (pstep == 3'd4);
      if (cfg_we) begin
        if (cfg_index == paw_pkg::RegRows) rows_in_use <= cfg_data;
        else cols_in_use <= cfg_data[3:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start && mode == paw_pkg::ModeQuery) begin
            ja <= row_a; lb <= row_b; r <= '0; c <= '0; ph <= 2'd0;
            n <= n_cfg;
            k <= k_cfg;
            sum <= '0; dot <= '0; djr <= '0; dlr <= '0; djl <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (ph == 2'd1) vj <= $signed(rd);
          if (ph == 2'd2) vl <= $signed(rd);
          if (ph == 2'd3) begin
            mstep <= 2'd0; state <= S_MUL;
          end
          ph <= ph + 2'd1;
        end
        S_MUL: begin
          mstep <= mstep + 2'd1;
          case (mstep)
            2'd0: dot <= dot + 38'(mprod);
            2'd1: djr <= djr + 38'(mprod);
            2'd2: dlr <= dlr + 38'(mprod);
            default: begin
              djl <= djl + 38'(mprod);
              ph <= 2'd0;
              if (4'(c) + 4'd1 == k) state <= S_ROW;
              else begin c <= c + 1'b1; state <= S_RD; end
            end
          endcase
        end
        S_ROW: begin
          if (djr == 0 && dlr == 0) begin
            sum <= sum + 40'(paw_pkg::TwoPiQ30); state <= S_P2;
          end else if (djr != 0 && dlr != 0 && djl != 0) begin
            mul_a <= 36'(djr); mul_b <= 36'(dlr); pstep <= 3'd0; state <= S_P1;
          end else begin
            sum <= sum + 40'(paw_pkg::PiQ30); state <= S_P2;
          end
        end
        S_P1: begin
          pstep <= pstep + 3'd1;
          case (pstep)
            3'd0: pp <= 84'(prod);
            3'd1: begin
              pp <= pp + (84'(prod) << 18);
              mul_a <= dmag;
              mul_b <= dmag;
            end
            3'd2: qq <= 84'(prod);
            3'd3: qq <= qq + (84'(prod) << 18);
            default: begin
              areq.rad <= (qq <= pp) ? pp - qq : '0;
              areq.dot <= 43'(-dot);
              state <= S_ANG;
            end
          endcase
        end
        S_ANG: begin
          if (arsp.done) begin
            sum <= sum + 40'(arsp.angle);
            state <= S_P2;
          end
        end
        S_P2: begin
          dot <= '0; djr <= '0; dlr <= '0; djl <= '0; c <= '0; ph <= 2'd0;
          mstep <= 2'd0;
          if (7'(r) + 7'd1 == n) begin
            num <= 41'(sum) + (41'(n) << 13);
            den <= 41'(n) << 14;
            rem <= '0; quo <= '0; dcnt <= '0;
            state <= S_DIV;
          end else begin
            r <= r + 1'b1; state <= S_RD;
          end
        end
        S_DIV: begin
          if (!rem_try[41]) begin
            rem <= rem_try[40:0]; quo <= {quo[39:0], 1'b1};
          end else begin
            rem <= {rem[39:0], num[40]}; quo <= {quo[39:0], 1'b0};
          end
          num <= num << 1;
          if (dcnt == 6'd40) state <= S_OUT;
          dcnt <= dcnt + 6'd1;
        end
        S_OUT: begin
          weight <= quo[18:0]; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done while busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ANG) |-> busy) else $error("busy low in angle wait");
  a_ang_only: assert property (@(posedge clk) disable iff (rst)
    arsp.done |-> state == S_ANG) else $error("stray angle result");
`endif
endmodule
`default_nettype wire

@@ dv/tb_projection_angle_weight.sv @@
// testbench for projection_angle_weight: random sample writes and pair queries checked by a scoreboard
`timescale 1ns / 100ps
`default_nettype none
module tb_projection_angle_weight;
  localparam int FullRows = 8;

  class weight_scoreboard;
    logic signed [15:0] mem [paw_pkg::MaxRows][paw_pkg::MaxCols];
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    logic [18:0] expected_weights [$];
    int errors;

    function new();
      rows_cfg = 64;
      cols_cfg = 8;
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [6:0] val);
      if (idx == paw_pkg::RegRows) rows_cfg = val;
      else cols_cfg = val & 7'h0f;
    endfunction

    function longint unsigned root_floor(logic [127:0] v);
      logic [127:0] r, c;
      r = 0;
      for (int b = 41; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r[63:0];
    endfunction

    function longint angle_of(longint unsigned ymag, longint xv);
      longint unsigned xmag, m;
      longint x, y, z, xs, ys;
      longint tab [31];
      tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
              16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
              131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
              128, 64, 32, 16, 8, 4, 2, 1};
      xmag = xv < 0 ? -xv : xv;
      m = xmag > ymag ? xmag : ymag;
      if (m == 0) return 0;
      while (m < (64'd1 << 40)) begin
        m = m << 1;
        xmag = xmag << 1;
        ymag = ymag << 1;
      end
      if (xv < 0) begin
        x = ymag;
        y = xmag;
        z = paw_pkg::HalfPiQ30;
      end else begin
        x = xmag;
        y = ymag;
        z = 0;
      end
      for (int i = 0; i < 31; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + tab[i];
        end else if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - tab[i];
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(paw_pkg::PiQ30)) z = paw_pkg::PiQ30;
      return z;
    endfunction

    function logic [18:0] pair_weight(int unsigned j, int unsigned l);
      int unsigned n, k;
      longint dot, djr, dlr, djl, a, b, d;
      longint unsigned sum, dmag, s;
      logic [127:0] p, q;
      n = rows_cfg == 0 ? 1 : (rows_cfg > paw_pkg::MaxRows ? paw_pkg::MaxRows : rows_cfg);
      k = cols_cfg == 0 ? 1 : (cols_cfg > paw_pkg::MaxCols ? paw_pkg::MaxCols : cols_cfg);
      sum = 0;
      for (int r = 0; r < n; r++) begin
        dot = 0; djr = 0; dlr = 0; djl = 0;
        for (int c = 0; c < k; c++) begin
          a = longint'(mem[j][c]) - longint'(mem[r][c]);
          b = longint'(mem[l][c]) - longint'(mem[r][c]);
          d = longint'(mem[j][c]) - longint'(mem[l][c]);
          dot += a * b;
          djr += a * a;
          dlr += b * b;
          djl += d * d;
        end
        if (djr == 0 && dlr == 0) sum += paw_pkg::TwoPiQ30;
        else if (djr != 0 && dlr != 0 && djl != 0) begin
          dmag = dot < 0 ? -dot : dot;
          p = 128'(djr) * 128'(dlr);
          q = 128'(dmag) * 128'(dmag);
          s = q <= p ? root_floor(p - q) : 0;
          sum += angle_of(s, -dot);
        end else sum += paw_pkg::PiQ30;
      end
      return 19'((sum + (64'(n) << 13)) / (64'(n) << 14));
    endfunction

    function void note_input(logic [0:0] md, logic [5:0] ra, logic [5:0] rb,
                             logic [2:0] col, logic signed [15:0] smp);
      if (md == paw_pkg::ModeWrite) mem[ra][col] = smp;
      else expected_weights.push_back(pair_weight(ra, rb));
    endfunction

    function void check_result(logic [18:0] w);
      logic [18:0] exp_w;
      if (expected_weights.size() == 0) begin
        $error("weight: unexpected transaction, actual %0d", w);
        errors++;
        return;
      end
      exp_w = expected_weights.pop_front();
      if (w !== exp_w) begin
        $error("weight: expected %0d actual %0d", exp_w, w);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, cfg_we;
  logic [0:0] mode, cfg_index;
  logic [5:0] row_a, row_b;
  logic [2:0] column;
  logic signed [15:0] sample;
  logic [18:0] weight;
  logic [6:0] cfg_data;
  weight_scoreboard sb;

  projection_angle_weight dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .row_a(row_a), .row_b(row_b), .column(column), .sample(sample),
    .done(done), .weight(weight), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(weight);
  end

  task automatic send(logic [0:0] md, logic [5:0] ra, logic [5:0] rb,
                      logic [2:0] col, logic signed [15:0] smp);
    @(negedge clk);
    start <= 1'b1;
    mode <= md;
    row_a <= ra;
    row_b <= rb;
    column <= col;
    sample <= smp;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(md, ra, rb, col, smp);
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return;
    if (p < 90) pause($urandom_range(0, 3));
    else pause($urandom_range(20, 200));
  endtask

  task automatic drain();
    pause(0);
    while (sb.expected_weights.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'(int'($urandom_range(0, 4)) - 2);
      default: return 16'($urandom);
    endcase
  endfunction

  // only column zero is filled above the first rows in the initial fill
  function automatic logic [5:0] rand_row();
    int unsigned n, lim;
    lim = sb.cols_cfg > 1 ? FullRows : paw_pkg::MaxRows;
    n = sb.rows_cfg == 0 ? 1 : (sb.rows_cfg > paw_pkg::MaxRows ? paw_pkg::MaxRows : sb.rows_cfg);
    if (n > lim) n = lim;
    if ($urandom_range(0, 1)) return 6'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) return 6'($urandom_range(0, n - 1));
    return 6'($urandom_range(0, lim - 1));
  endfunction

  initial begin
    logic [6:0] phase_rows [7];
    logic [6:0] phase_cols [7];
    logic signed [15:0] v;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    mode = paw_pkg::ModeWrite;
    row_a = '0;
    row_b = '0;
    column = '0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = paw_pkg::RegRows;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full rows first, column zero of the rest; row 1 copies row 0, rows 2 and 3 at the extremes
    for (int r = 0; r < paw_pkg::MaxRows; r++) begin
      for (int c = 0; c < paw_pkg::MaxCols; c++) begin
        if (r < FullRows || c == 0) begin
          case (r)
            1: v = sb.mem[0][c];
            2: v = 16'sh7fff;
            3: v = -16'sh8000;
            default: v = rand_sample();
          endcase
          send(paw_pkg::ModeWrite, 6'(r), 6'($urandom), 3'(c), v);
        end
      end
    end

    write_reg(paw_pkg::RegRows, 7'(FullRows));
    write_reg(paw_pkg::RegCols, 7'd8);
    send(paw_pkg::ModeQuery, 6'd0, 6'd0, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd0, 6'd1, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd0, 6'd2, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd2, 6'd3, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd3, 6'd2, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd7, 6'd0, 3'($urandom), 16'($urandom));
    send(paw_pkg::ModeQuery, 6'd5, 6'd6, 3'($urandom), 16'($urandom));

    phase_rows = '{7'd1, 7'd0, 7'd127, 7'd5, 7'd8, 7'd3, 7'd64};
    phase_cols = '{7'd1, 7'd0, 7'd1, 7'd3, 7'd15, 7'd8, 7'd0};
    for (int ph = 0; ph < 7; ph++) begin
      write_reg(paw_pkg::RegRows, phase_rows[ph]);
      write_reg(paw_pkg::RegCols, phase_cols[ph]);
      for (int i = 0; i < 9; i++) begin
        if (ph == 2 && i == 4) drain();
        if ($urandom_range(0, 9) < 4)
          send(paw_pkg::ModeQuery, rand_row(), rand_row(), 3'($urandom), 16'($urandom));
        else
          send(paw_pkg::ModeWrite, rand_row(), 6'($urandom), 3'($urandom), rand_sample());
        random_gap();
      end
    end

    pause(0);
    while (sb.expected_weights.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire
